/* rtl/sbcs_pkg.sv */
// sbcs_pkg: shared types, register map and extension helpers for the swept box collision scan
// no dependencies; imported by swept_box_collision_scan and tb_top

package sbcs_pkg;

    localparam int CoordW   = 16;
    localparam int MoveW    = 12;
    localparam int SizeW    = 12;
    // coordinate sums stay within 18 signed bits
    localparam int CalcW    = 18;
    localparam int AddrW    = 4;
    localparam int DataW    = 32;
    localparam int InDataW  = 112;
    localparam int InUserW  = 2;
    localparam int OutDataW = 32;
    localparam int OutUserW = 4;

    localparam logic [SizeW-1:0] SizeReset = 12'd32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] RegUnitWidth   = 2'd0;
    localparam logic [1:0] RegUnitHeight  = 2'd1;
    localparam logic [1:0] RegPlayerWidth = 2'd2;

    // hit flag bit positions
    localparam int FlagLeft   = 0;
    localparam int FlagRight  = 1;
    localparam int FlagTop    = 2;
    localparam int FlagBottom = 3;

    typedef struct packed {
        logic [CoordW-1:0] unit_left;
        logic [CoordW-1:0] unit_top;
        logic [MoveW-1:0]  move_x;
        logic [MoveW-1:0]  move_y;
        logic              facing_left;
        logic [CoordW-1:0] box_left;
        logic [CoordW-1:0] box_top;
        logic [SizeW-1:0]  box_width;
        logic [SizeW-1:0]  box_height;
        logic              first_box;
        logic              last_box;
    } item_t;

    function automatic logic signed [CalcW-1:0] sext_coord(input logic [CoordW-1:0] v);
        sext_coord = $signed({{(CalcW-CoordW){v[CoordW-1]}}, v});
    endfunction

    function automatic logic signed [CalcW-1:0] sext_move(input logic [MoveW-1:0] v);
        sext_move = $signed({{(CalcW-MoveW){v[MoveW-1]}}, v});
    endfunction

    function automatic logic signed [CalcW-1:0] zext_size(input logic [SizeW-1:0] v);
        zext_size = $signed({{(CalcW-SizeW){1'b0}}, v});
    endfunction

endpackage

/* rtl/swept_box_collision_scan.sv */
// swept_box_collision_scan: per-box swept contact tests with sticky per-frame hit flags
// depends on sbcs_pkg (types, register map, sign/zero extension helpers)
//
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | s_tdata boxes+motion, s_tuser flags, s_tlast last box
//  m_*     | out | m_tvalid / m_tready  | m_tdata floor/ceiling edges, m_tuser hit flags
//  apb     | in  | psel & penable       | paddr, pwdata, prdata, pready tied high
//
// one box per cycle unless a last box stalls: a request lands in the input register, is scanned
// from there, and its result (last box only) is written to the output register as it advances
// the sticky flags and edge stores are the only loop; they update in the scan cycle
// a result waiting in the output register stalls only a following last box
// reset clears flags, stores, valids; size registers return to 32

module swept_box_collision_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    // apb
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbcs_pkg::AddrW-1:0]    paddr,
    input  logic [sbcs_pkg::DataW-1:0]    pwdata,
    output logic [sbcs_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // unit_left, unit_top, move_x, move_y, box_left, box_top, box_width, box_height
    input  logic [sbcs_pkg::InDataW-1:0]  s_tdata,
    // facing_left, first_box
    input  logic [sbcs_pkg::InUserW-1:0]  s_tuser,
    input  logic                          s_tlast,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // floor_edge, ceiling_edge
    output logic [sbcs_pkg::OutDataW-1:0] m_tdata,
    // hit_left, hit_right, hit_top, hit_bottom
    output logic [sbcs_pkg::OutUserW-1:0] m_tuser
);
    import sbcs_pkg::*;

    logic [SizeW-1:0]  unit_width_reg;
    logic [SizeW-1:0]  unit_height_reg;
    logic [SizeW-1:0]  player_width_reg;

    item_t             in_reg;
    logic              in_valid_reg;
    logic [3:0]        flags_reg, flags_next, flags_scan;
    logic [CoordW-1:0] floor_reg, floor_next, floor_scan;
    logic [CoordW-1:0] ceil_reg, ceil_next, ceil_scan;
    logic              done_reg, done_next;
    logic [3:0]        base_flags;
    logic [CoordW-1:0] base_floor, base_ceil;
    logic              base_done;

    logic              out_valid_reg;
    logic [3:0]        out_flags_reg;
    logic [CoordW-1:0] out_floor_reg, out_ceil_reg;

    logic              cfg_write;
    logic              advance;

    logic signed [CalcW-1:0] ul, ut, mx, my, w, h, pw;
    logic signed [CalcW-1:0] cl, cr, fl, fr, ctop, cbot, ftop, fbot;
    logic signed [CalcW-1:0] obl, obt, obr, obb;
    logic                    rows_shared, cols_shared, hit_l, hit_r, hit_t, hit_b;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_width_reg   <= SizeReset;
            unit_height_reg  <= SizeReset;
            player_width_reg <= SizeReset;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                RegUnitWidth:   unit_width_reg   <= pwdata[SizeW-1:0];
                RegUnitHeight:  unit_height_reg  <= pwdata[SizeW-1:0];
                RegPlayerWidth: player_width_reg <= pwdata[SizeW-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            RegUnitWidth:   prdata = {{(DataW-SizeW){1'b0}}, unit_width_reg};
            RegUnitHeight:  prdata = {{(DataW-SizeW){1'b0}}, unit_height_reg};
            RegPlayerWidth: prdata = {{(DataW-SizeW){1'b0}}, player_width_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // a last box needs room in the output register; other boxes always move on
    assign advance  = in_valid_reg && (!in_reg.last_box || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.unit_left   <= s_tdata[15:0];
            in_reg.unit_top    <= s_tdata[31:16];
            in_reg.move_x      <= s_tdata[43:32];
            in_reg.move_y      <= s_tdata[55:44];
            in_reg.box_left    <= s_tdata[71:56];
            in_reg.box_top     <= s_tdata[87:72];
            in_reg.box_width   <= s_tdata[99:88];
            in_reg.box_height  <= s_tdata[111:100];
            in_reg.facing_left <= s_tuser[0];
            in_reg.first_box   <= s_tuser[1];
            in_reg.last_box    <= s_tlast;
        end
    end

    // ---------------- box scan ----------------
    always_comb
    begin
        ul  = sext_coord(in_reg.unit_left);
        ut  = sext_coord(in_reg.unit_top);
        mx  = sext_move(in_reg.move_x);
        my  = sext_move(in_reg.move_y);
        w   = zext_size(unit_width_reg);
        h   = zext_size(unit_height_reg);
        pw  = zext_size(player_width_reg);
        obl = sext_coord(in_reg.box_left);
        obt = sext_coord(in_reg.box_top);
        obr = obl + zext_size(in_reg.box_width);
        obb = obt + zext_size(in_reg.box_height);

        // facing left anchors the box on its right edge
        if (in_reg.facing_left)
        begin
            cr = ul + pw;
            cl = cr - w;
            fr = cr + mx;
            fl = fr - w;
        end
        else
        begin
            cl = ul;
            cr = ul + w;
            fl = ul + mx;
            fr = fl + w;
        end
        ctop = ut;
        cbot = ut + h;
        ftop = ut + my;
        fbot = ftop + h;

        rows_shared = (cbot > obt) && (ctop < obb);
        cols_shared = (cr >= obl) && (cl <= obr);
        // a moving side must start outside the box
        hit_l = rows_shared && (fl <= obr) && (fr >= obr) && ((mx == '0) || (cl >= obr));
        hit_r = rows_shared && (fr >= obl) && (fl <= obl) && ((mx == '0) || (cr <= obl));
        hit_t = cols_shared && (ftop <= obb) && (fbot >= obb);
        hit_b = cols_shared && (fbot >= obt) && (ftop <= obt);
    end

    // ---------------- frame accumulators ----------------
    always_comb
    begin
        if (in_reg.first_box)
        begin
            base_flags = '0;
            base_floor = '0;
            base_ceil  = '0;
            base_done  = 1'b0;
        end
        else
        begin
            base_flags = flags_reg;
            base_floor = floor_reg;
            base_ceil  = ceil_reg;
            base_done  = done_reg;
        end

        flags_scan = base_flags;
        floor_scan = base_floor;
        ceil_scan  = base_ceil;
        if (!base_done)
        begin
            flags_scan = base_flags | {hit_b, hit_t, hit_r, hit_l};
            if (hit_t)
                ceil_scan = obb[CoordW-1:0];
            if (hit_b)
                floor_scan = obt[CoordW-1:0];
        end

        flags_next = flags_scan;
        floor_next = floor_scan;
        ceil_next  = ceil_scan;
        done_next  = base_done || ((flags_scan[FlagLeft] || flags_scan[FlagRight]) &&
                                   (flags_scan[FlagTop] || flags_scan[FlagBottom]));
        // a result closes the frame
        if (in_reg.last_box)
        begin
            flags_next = '0;
            floor_next = '0;
            ceil_next  = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            floor_reg <= '0;
            ceil_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
            floor_reg <= floor_next;
            ceil_reg  <= ceil_next;
            done_reg  <= done_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_reg.last_box)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_reg.last_box)
        begin
            out_flags_reg <= flags_scan;
            out_floor_reg <= floor_scan;
            out_ceil_reg  <= ceil_scan;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flags_reg;
    assign m_tdata  = {out_ceil_reg, out_floor_reg};

    // ---------------- assertions ----------------
    a_done_needs_both_axes: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((flags_reg[FlagLeft] || flags_reg[FlagRight]) &&
                      (flags_reg[FlagTop] || flags_reg[FlagBottom])))
        else $error("frame done without a horizontal and a vertical hit");

    a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.last_box) |=> out_valid_reg)
        else $error("last box did not produce a result");

    a_last_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.last_box) |=> (flags_reg == '0 && !done_reg &&
                                          floor_reg == '0 && ceil_reg == '0))
        else $error("frame state not cleared after result");

    a_request_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted request lost before scan");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(advance && in_reg.last_box))
        else $error("pending result overwritten");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for swept_box_collision_scan, streams obstacle boxes and
// compares each frame result against an in-bench collision predictor
// depends on sbcs_pkg and the swept_box_collision_scan rtl

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbcs_pkg::*;

    typedef struct packed {
        logic [3:0]        hits;
        logic [CoordW-1:0] floor_edge;
        logic [CoordW-1:0] ceiling_edge;
    } scan_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrW-1:0]    paddr;
    logic [DataW-1:0]    pwdata;
    logic [DataW-1:0]    prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    // unit_left, unit_top, move_x, move_y, box_left, box_top, box_width, box_height
    logic [InDataW-1:0]  s_tdata;
    // facing_left, first_box
    logic [InUserW-1:0]  s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    // floor_edge, ceiling_edge
    logic [OutDataW-1:0] m_tdata;
    // hit_left, hit_right, hit_top, hit_bottom
    logic [OutUserW-1:0] m_tuser;

    // predictor state and its copy of the size registers
    logic [SizeW-1:0]  cfg_unit_w;
    logic [SizeW-1:0]  cfg_unit_h;
    logic [SizeW-1:0]  cfg_player_w;
    logic [3:0]        acc_flags;
    logic [CoordW-1:0] acc_floor;
    logic [CoordW-1:0] acc_ceiling;
    bit                acc_done;

    scan_result_t frame_results_q[$];
    int           fail_count;
    int           mismatch_count;
    bit           sender_idle;
    bit           receiver_idle;
    bit           hold_off;

    swept_box_collision_scan u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_frame_state();
        acc_flags   = '0;
        acc_floor   = '0;
        acc_ceiling = '0;
        acc_done    = 1'b0;
    endtask

    // one obstacle against the unit box, then the frame result on the last box
    task automatic scan_obstacle(input item_t it);
        int ul, ut, mx, my, bl, bt, br, bb, w, h, pw;
        int cl, cr, nl, nr, ctop, cbot, ntop, nbot;
        bit side_l, side_r;
        scan_result_t res;
        if (it.first_box)
            clear_frame_state();
        if (!acc_done)
        begin
            ul = int'($signed(it.unit_left));
            ut = int'($signed(it.unit_top));
            mx = int'($signed(it.move_x));
            my = int'($signed(it.move_y));
            bl = int'($signed(it.box_left));
            bt = int'($signed(it.box_top));
            br = bl + int'(it.box_width);
            bb = bt + int'(it.box_height);
            w  = int'(cfg_unit_w);
            h  = int'(cfg_unit_h);
            pw = int'(cfg_player_w);
            if (it.facing_left)
            begin
                cr = ul + pw;
                cl = cr - w;
                nr = ul + mx + pw;
                nl = nr - w;
            end
            else
            begin
                cl = ul;
                cr = ul + w;
                nl = ul + mx;
                nr = nl + w;
            end
            ctop = ut;
            cbot = ut + h;
            ntop = ut + my;
            nbot = ntop + h;
            if (cbot > bt && ctop < bb)
            begin
                side_l = nl <= br && nr >= br;
                side_r = nr >= bl && nl <= bl;
                // a side that moves must start outside the obstacle
                if (cl != nl)
                    side_l = side_l && cl >= br;
                if (cr != nr)
                    side_r = side_r && cr <= bl;
                if (side_l)
                    acc_flags[FlagLeft] = 1'b1;
                if (side_r)
                    acc_flags[FlagRight] = 1'b1;
            end
            if (cr >= bl && cl <= br)
            begin
                if (ntop <= bb && nbot >= bb)
                begin
                    acc_flags[FlagTop] = 1'b1;
                    acc_ceiling = bb[CoordW-1:0];
                end
                if (nbot >= bt && ntop <= bt)
                begin
                    acc_flags[FlagBottom] = 1'b1;
                    acc_floor = bt[CoordW-1:0];
                end
            end
            if ((acc_flags[FlagLeft] || acc_flags[FlagRight]) &&
                (acc_flags[FlagTop] || acc_flags[FlagBottom]))
                acc_done = 1'b1;
        end
        if (it.last_box)
        begin
            res.hits         = acc_flags;
            res.floor_edge   = acc_floor;
            res.ceiling_edge = acc_ceiling;
            frame_results_q.push_back(res);
            clear_frame_state();
        end
    endtask

    function automatic item_t mk_box(input int ul, input int ut, input int mx, input int my,
                                     input bit fl, input int bl, input int bt,
                                     input int bw, input int bh, input bit first, input bit last);
        item_t it;
        it.unit_left   = ul[CoordW-1:0];
        it.unit_top    = ut[CoordW-1:0];
        it.move_x      = mx[MoveW-1:0];
        it.move_y      = my[MoveW-1:0];
        it.facing_left = fl;
        it.box_left    = bl[CoordW-1:0];
        it.box_top     = bt[CoordW-1:0];
        it.box_width   = bw[SizeW-1:0];
        it.box_height  = bh[SizeW-1:0];
        it.first_box   = first;
        it.last_box    = last;
        return it;
    endfunction

    // fully random request, every field over its whole range
    function automatic item_t rand_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return item_t'(raw[$bits(item_t)-1:0]);
    endfunction

    function automatic int rand_size();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, 96);
    endfunction

    function automatic int rand_move();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom_range(0, 4095) - 2048;
            default: return $urandom_range(0, 80) - 40;
        endcase
    endfunction

    // sends one request; tvalid stays high afterward unless the next call idles first or a drain lowers it
    task automatic send_box(input item_t it);
        int gap;
        gap = sender_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.box_height, it.box_width, it.box_top, it.box_left,
                     it.move_y, it.move_x, it.unit_top, it.unit_left};
        s_tuser  <= {it.first_box, it.facing_left};
        s_tlast  <= it.last_box;
        do @(posedge clk); while (!s_tready);
        scan_obstacle(it);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom_range(0, 1048575)), value[SizeW-1:0]};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegUnitWidth:   cfg_unit_w   = value[SizeW-1:0];
            RegUnitHeight:  cfg_unit_h   = value[SizeW-1:0];
            RegPlayerWidth: cfg_player_w = value[SizeW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int unsigned uw, input int unsigned uh,
                             input int unsigned pw);
        apb_write(RegUnitWidth, uw);
        apb_write(RegUnitHeight, uh);
        apb_write(RegPlayerWidth, pw);
    endtask

    // waits for every pending result, then lets the pipeline settle
    task automatic drain_results();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (frame_results_q.size() != 0 && n < 50000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic send_random_frames(input int n_items);
        int sent, nbox, ul, ut, mx, my;
        bit fl;
        item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            nbox = $urandom_range(1, 6);
            ul   = $urandom_range(0, 65535) - 32768;
            ut   = $urandom_range(0, 65535) - 32768;
            mx   = rand_move();
            my   = rand_move();
            fl   = 1'($urandom_range(0, 1));
            for (int i = 0; i < nbox; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    it = rand_item();
                else
                    it = mk_box(ul, ut, mx, my, fl,
                                ul + $urandom_range(0, 192) - 96,
                                ut + $urandom_range(0, 192) - 96,
                                rand_size(), rand_size(),
                                (i == 0) && ($urandom_range(0, 9) != 0),
                                (i == nbox - 1) && ($urandom_range(0, 9) != 0));
                send_box(it);
            end
            sent += nbox;
        end
    endtask

    task automatic test_directed_cases();
        // right side contact while moving right
        send_box(mk_box(100, 100, 10, 0, 0, 140, 90, 20, 50, 1, 1));
        // facing left, left side contact
        send_box(mk_box(200, 100, -10, 0, 1, 150, 90, 40, 50, 1, 1));
        // floor and ceiling both touched
        send_box(mk_box(100, 100, 0, 20, 0, 90, 140, 60, 10, 1, 1));
        // moving side already inside the obstacle
        send_box(mk_box(145, 100, 10, 0, 0, 140, 90, 20, 50, 1, 1));
        // frame completes on the second box, the third adds no hits
        send_box(mk_box(100, 100, 10, 0, 0, 140, 90, 20, 50, 1, 0));
        send_box(mk_box(100, 100, 0, 20, 0, 90, 140, 60, 10, 0, 0));
        send_box(mk_box(100, 100, 0, -20, 0, 90, 60, 60, 30, 0, 1));
        // after a result the next box starts clean without a first mark
        send_box(mk_box(100, 100, 10, 0, 0, 140, 90, 20, 50, 1, 1));
        send_box(mk_box(0, 0, 0, 0, 0, 1000, 1000, 5, 5, 0, 1));
        // no first mark, hits keep accumulating
        send_box(mk_box(200, 100, -10, 0, 0, 150, 90, 40, 50, 0, 0));
        send_box(mk_box(0, 0, 0, 0, 0, 1000, 1000, 5, 5, 0, 1));
        // first mark in mid frame drops earlier hits
        send_box(mk_box(100, 100, 10, 0, 0, 140, 90, 20, 50, 1, 0));
        send_box(mk_box(0, 0, 0, 0, 0, 1000, 1000, 5, 5, 1, 1));
        // obstacle bottom beyond 16 bits is recorded wrapped
        send_box(mk_box(0, 32767, 0, 2047, 0, 0, 32000, 100, 2824, 1, 1));
        send_box(mk_box(-32768, -32768, -2048, -2048, 1, -32768, -32768, 4095, 4095, 1, 1));
        send_box(mk_box(32767, 32767, 2047, 2047, 1, 32767, 32767, 4095, 4095, 1, 1));
        send_box(mk_box(32767, -32768, 2047, -2048, 0, -32768, 32767, 0, 0, 1, 1));
        send_box(mk_box(-1, -1, -1, -1, 1, -1, -1, 4095, 0, 1, 1));
        // zero sized obstacle right at the unit corner
        send_box(mk_box(100, 100, 0, 0, 0, 132, 132, 0, 0, 1, 1));
        drain_results();
    endtask

    task automatic test_size_sweep();
        set_sizes(4095, 4095, 4095);
        send_random_frames(150);
        drain_results();
        set_sizes(0, 0, 0);
        send_random_frames(150);
        drain_results();
        set_sizes($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
        send_random_frames(150);
        drain_results();
        set_sizes(16, 48, 40);
        send_random_frames(150);
        drain_results();
        // back to reset sizes with both sides streaming flat out
        set_sizes(32, 32, 32);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_random_frames(100);
        drain_results();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int nbox;
        sender_idle = 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                for (int i = 0; i < 60; i += nbox)
                begin
                    nbox = $urandom_range(1, 2);
                    for (int j = 0; j < nbox; j++)
                        send_box(mk_box(100, 100, 10, $urandom_range(0, 40) - 20, j[0],
                                        $urandom_range(60, 160), $urandom_range(60, 160),
                                        $urandom_range(0, 60), $urandom_range(0, 60),
                                        j == 0, j == nbox - 1));
                end
            end
        join
        drain_results();
        sender_idle = 1'b1;
    endtask

    task automatic test_random_noise();
        item_t it;
        for (int i = 0; i < 150; i++)
        begin
            it = rand_item();
            it.last_box = ($urandom_range(0, 2) == 0);
            send_box(it);
        end
        drain_results();
    endtask

    // result side: random stalls per result, plus the long hold-off
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = receiver_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0 || hold_off)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: hits %b floor %h ceiling %h",
                             m_tuser, m_tdata[15:0], m_tdata[31:16]);
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (m_tuser !== want.hits || m_tdata[15:0] !== want.floor_edge ||
                    m_tdata[31:16] !== want.ceiling_edge)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: hits %b/%b floor %h/%h ceiling %h/%h (exp/act)",
                                 want.hits, m_tuser, want.floor_edge, m_tdata[15:0],
                                 want.ceiling_edge, m_tdata[31:16]);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        hold_off      = 1'b0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        fail_count     = 0;
        mismatch_count = 0;
        cfg_unit_w    = SizeReset;
        cfg_unit_h    = SizeReset;
        cfg_player_w  = SizeReset;
        clear_frame_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_size_sweep();
        test_output_backpressure();
        test_random_noise();

        if (fail_count == 0 && frame_results_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
